// File: hdl/string_to_int_custom_radix_macros.svh
// Assertion macros used by the string-to-integer back end.
`ifndef STRING_TO_INT_CUSTOM_RADIX_MACROS_SVH
`define STRING_TO_INT_CUSTOM_RADIX_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define STOI_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("stoi assertion failed");
// Check that pre in one cycle implies post in the next.
`define STOI_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("stoi assertion failed");
`else
`define STOI_ASSERT(label, prop)
`define STOI_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: hdl/stoi_pkg.sv
// Types, constants and helpers of the string-to-integer converter.
package stoi_pkg;

   localparam int CHAR_W      = 8;
   localparam int NUM_W       = 32;
   localparam int CFG_W       = 64;
   localparam int RLEN_W      = 5;
   localparam int DIG_W       = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int ALPHA_SLOTS = 16;
   localparam int MAX_RADIX   = 16;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIGIT_LOW  = 2'd0,
      CSR_DIGIT_HIGH = 2'd1,
      CSR_RADIX_LEN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ALPHA_SLOTS-1:0][CHAR_W-1:0] chars;
      logic [RLEN_W-1:0]                  used_len;
      logic                               alphabet_ok;
   } cfg_type;

   typedef struct packed {
      logic             last;
      logic             is_skip;
      logic             is_minus;
      logic             is_digit;
      logic [DIG_W-1:0] digit;
   } token_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] number;
      logic                    alphabet_ok;
   } result_type;

   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

endpackage

// File: hdl/stoi_csr.sv
// Configuration registers and alphabet validity check.
module stoi_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [stoi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stoi_pkg::CFG_W-1:0]           csr_wdata,
   output stoi_pkg::cfg_type                    cfg
);
   import stoi_pkg::*;

   logic [CFG_W-1:0]  chars_low_ff;
   logic [CFG_W-1:0]  chars_high_ff;
   logic [RLEN_W-1:0] radix_len_ff;
   logic              ok_ff;
   logic              ok_in;
   logic [ALPHA_SLOTS-1:0][CHAR_W-1:0] chars;

   assign chars = {chars_high_ff, chars_low_ff};

   // Judge the alphabet from the stored registers; the verdict is registered in ok_ff.
   always_comb begin
      ok_in = (radix_len_ff >= RLEN_W'(2)) && (radix_len_ff <= RLEN_W'(MAX_RADIX));
      for (int i = 0; i < ALPHA_SLOTS; i++) begin
         if (RLEN_W'(i) < radix_len_ff) begin
            if ((chars[i] == CHAR_NUL) || (chars[i] == CHAR_PLUS) ||
                (chars[i] == CHAR_MINUS) || is_space(chars[i])) begin
               ok_in = 1'b0;
            end
            for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
               if ((RLEN_W'(j) < radix_len_ff) && (chars[j] == chars[i])) begin
                  ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
         radix_len_ff  <= '0;
         ok_ff         <= 1'b0;
      end else begin
         ok_ff <= ok_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_DIGIT_LOW:  chars_low_ff  <= csr_wdata;
               CSR_DIGIT_HIGH: chars_high_ff <= csr_wdata;
               CSR_RADIX_LEN:  radix_len_ff  <= csr_wdata[RLEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.chars       = chars;
   assign cfg.used_len    = (radix_len_ff > RLEN_W'(MAX_RADIX)) ? RLEN_W'(MAX_RADIX)
                                                                : radix_len_ff;
   assign cfg.alphabet_ok = ok_ff;

endmodule

// File: hdl/stoi_front.sv
// Front end: classifies each request character against the alphabet.
module stoi_front (
   input  logic [stoi_pkg::CHAR_W-1:0] char_in,
   input  logic                        last_char,
   input  stoi_pkg::cfg_type           cfg,
   output stoi_pkg::token_type         token
);
   import stoi_pkg::*;

   logic             hit;
   logic [DIG_W-1:0] digit;

   // Scan from the top so the lowest matching position wins.
   always_comb begin
      hit   = 1'b0;
      digit = '0;
      for (int i = ALPHA_SLOTS - 1; i >= 0; i--) begin
         if ((RLEN_W'(i) < cfg.used_len) && (cfg.chars[i] == char_in)) begin
            hit   = 1'b1;
            digit = DIG_W'(i);
         end
      end
   end

   assign token.last     = last_char;
   assign token.is_skip  = is_space(char_in) || (char_in == CHAR_PLUS);
   assign token.is_minus = (char_in == CHAR_MINUS);
   assign token.is_digit = hit && (char_in != CHAR_NUL);
   assign token.digit    = digit;

endmodule

// File: hdl/stoi_fifo.sv
// Small synchronous queue used between front and back and at the result side.
module stoi_fifo #(
   parameter type data_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  data_type push_data,
   output logic     full,
   input  logic     pop,
   output data_type pop_data,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   data_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

// File: hdl/stoi_back.sv
// Back end: parse state machine, multiply-accumulate and result forming.
`include "string_to_int_custom_radix_macros.svh"
module stoi_back (
   input  logic                   clock,
   input  logic                   reset,
   input  stoi_pkg::cfg_type      cfg,
   input  stoi_pkg::token_type    token,
   input  logic                   token_empty,
   output logic                   token_pop,
   input  logic                   result_full,
   output logic                   result_push,
   output stoi_pkg::result_type   result
);
   import stoi_pkg::*;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [NUM_W-1:0] mac;
   logic [NUM_W-1:0] value;

   assign mac = NUM_W'(acc_ff * NUM_W'(cfg.used_len)) + NUM_W'(token.digit);

   always_comb begin
      phase_in    = phase_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      // A last request needs room on the result side.
      token_pop   = !token_empty && (!token.last || !result_full);
      result_push = token_pop && token.last;

      if (token_pop) begin
         priority if (phase_ff == PH_PREFIX && token.is_skip) begin
            // hold: whitespace or plus in the prefix
         end else if (phase_ff == PH_PREFIX && token.is_minus) begin
            neg_in = !neg_ff;
         end else if (phase_ff != PH_DONE) begin
            if (token.is_digit) begin
               acc_in   = mac;
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end else begin
            // drop: the number has already ended
         end
      end

      value = neg_in ? (NUM_W'(0) - acc_in) : acc_in;
      result.alphabet_ok = cfg.alphabet_ok;
      result.number      = cfg.alphabet_ok ? signed'(value) : '0;

      if (result_push) begin
         phase_in = PH_PREFIX;
         neg_in   = 1'b0;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         acc_ff   <= acc_in;
      end
   end

   `STOI_ASSERT(a_push_on_last, result_push |-> (token_pop && token.last))
   `STOI_ASSERT_NEXT(a_clear_after_last, token_pop && token.last,
      phase_ff == PH_PREFIX && !neg_ff && acc_ff == '0)
   `STOI_ASSERT(a_invalid_gives_zero,
      (result_push && !cfg.alphabet_ok) |-> (result.number == '0))
   `STOI_ASSERT_NEXT(a_done_holds, phase_ff == PH_DONE && !(token_pop && token.last),
      phase_ff == PH_DONE)

endmodule

// File: hdl/string_to_int_custom_radix.sv
// Throughput is one character request per clock while the input queue is not
// full: the back end does one multiply-accumulate (accumulator times radix
// length, plus digit) per cycle unless a last request waits on a full result
// queue. A request is classified against the alphabet combinationally as it
// is accepted, waits in a QUEUE_DEPTH-entry queue, and is then consumed by
// the back end; the result of the request marked last is pushed into a
// QUEUE_DEPTH-entry result queue as that request is consumed, and shows on
// the rsp_ ports (rsp_empty low) from the head of that queue until popped; a
// last request stays at the head of the input queue while the result queue
// is full, and req_full rises once the input queue fills behind it. The alphabet
// validity flag is registered from the configuration registers after a write.
module string_to_int_custom_radix #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [stoi_pkg::CHAR_W-1:0]          req_char_in,
   input  logic                                 req_last_char,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [stoi_pkg::NUM_W-1:0]    rsp_number,
   output logic                                 rsp_alphabet_ok,
   input  logic                                 csr_wr_en,
   input  logic [stoi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stoi_pkg::CFG_W-1:0]           csr_wdata
);
   import stoi_pkg::*;

   cfg_type    cfg;
   token_type  front_token;
   token_type  queue_token;
   logic       queue_empty;
   logic       queue_pop;
   logic       result_full;
   logic       result_push;
   result_type result_in;
   result_type result_out;

   stoi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   stoi_front u_front (
      .char_in   (req_char_in),
      .last_char (req_last_char),
      .cfg       (cfg),
      .token     (front_token)
   );

   stoi_fifo #(
      .data_type (token_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_token_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_token),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_token),
      .empty     (queue_empty)
   );

   stoi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .token       (queue_token),
      .token_empty (queue_empty),
      .token_pop   (queue_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (result_in)
   );

   stoi_fifo #(
      .data_type (result_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_in),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_out),
      .empty     (rsp_empty)
   );

   assign rsp_number      = result_out.number;
   assign rsp_alphabet_ok = result_out.alphabet_ok;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the custom-radix string-to-integer converter.
module testbench;
   import stoi_pkg::*;

   typedef enum logic [1:0] {
      PARSE_PREFIX,
      PARSE_DIGITS,
      PARSE_DONE
   } parse_phase_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTS = 20;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [CHAR_W-1:0]        req_char_in = '0;
   logic                     req_last_char = 1'b0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic signed [NUM_W-1:0]  rsp_number;
   logic                     rsp_alphabet_ok;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CFG_W-1:0]         csr_wdata = '0;

   // shadow copy of the configuration and the parse state
   logic [ALPHA_SLOTS-1:0][CHAR_W-1:0] alpha_chars = '0;
   logic [RLEN_W-1:0]                  radix_len = '0;
   parse_phase_type                    phase = PARSE_PREFIX;
   logic                               negative = 1'b0;
   logic [NUM_W-1:0]                   acc = '0;

   result_type       pending_numbers[$];
   logic [CHAR_W-1:0] text_buf[$];

   int push_idle_pct = 0;
   int pop_idle_pct = 0;
   int chars_sent = 0;
   int texts_sent = 0;
   int results_checked = 0;
   int alphabets_loaded = 0;
   int mismatches = 0;

   string_to_int_custom_radix uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_char_in     (req_char_in),
      .req_last_char   (req_last_char),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_number      (rsp_number),
      .rsp_alphabet_ok (rsp_alphabet_ok),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
   endfunction

   function automatic bit is_blocked(input logic [CHAR_W-1:0] c);
      return (c == CHAR_NUL) || (c == CHAR_PLUS) || (c == CHAR_MINUS) || is_blank(c);
   endfunction

   function automatic int used_len();
      return (radix_len > MAX_RADIX) ? MAX_RADIX : int'(radix_len);
   endfunction

   function automatic int digit_value(input logic [CHAR_W-1:0] c);
      if (c == CHAR_NUL) return -1;
      for (int i = 0; i < used_len(); i++)
         if (alpha_chars[i] == c) return i;
      return -1;
   endfunction

   function automatic bit alphabet_valid();
      if ((radix_len < 2) || (radix_len > MAX_RADIX)) return 1'b0;
      for (int i = 0; i < radix_len; i++) begin
         if (is_blocked(alpha_chars[i])) return 1'b0;
         for (int j = i + 1; j < radix_len; j++)
            if (alpha_chars[j] == alpha_chars[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [CHAR_W-1:0] prefix_char();
      case ($urandom_range(7))
         0, 1, 2: return CHAR_TAB + CHAR_W'($urandom_range(4));
         3:       return CHAR_SPACE;
         4:       return CHAR_PLUS;
         default: return CHAR_MINUS;
      endcase
   endfunction

   // Advance the parse by one accepted character; queue a result on the last one.
   task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
      int d;
      bit skip;
      result_type r;
      skip = (phase == PARSE_PREFIX) && (is_blank(c) || (c == CHAR_PLUS));
      if ((phase == PARSE_PREFIX) && (c == CHAR_MINUS)) begin
         negative = ~negative;
      end else if (!skip && (phase != PARSE_DONE)) begin
         d = digit_value(c);
         if (d >= 0) begin
            acc = acc * NUM_W'(used_len()) + NUM_W'(d);
            phase = PARSE_DIGITS;
         end else begin
            phase = PARSE_DONE;
         end
      end
      if (last) begin
         r.alphabet_ok = alphabet_valid();
         r.number = r.alphabet_ok ? (negative ? (NUM_W'(0) - acc) : acc) : '0;
         pending_numbers.push_back(r);
         phase = PARSE_PREFIX;
         negative = 1'b0;
         acc = '0;
         texts_sent++;
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_numbers.size() == 0) begin
            report_mismatch($sformatf("result with none pending: number %0d ok %0b",
                                      rsp_number, rsp_alphabet_ok));
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_number !== want.number)
               report_mismatch($sformatf("number %0d, predicted %0d",
                                         rsp_number, want.number));
            if (rsp_alphabet_ok !== want.alphabet_ok)
               report_mismatch($sformatf("alphabet_ok %0b, predicted %0b",
                                         rsp_alphabet_ok, want.alphabet_ok));
            results_checked++;
         end
      end
   end

   // Send one character request; push stays high so back-to-back requests need no toggle.
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
      while ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_char_in <= c;
      req_last_char <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      parse_char(c, last);
      chars_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   // Drop push, drain all pending results and let the back end finish.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_alphabet(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input logic [RLEN_W-1:0] len, input bit spare);
      logic [CFG_W-1:0] word;
      word = {$urandom, $urandom};
      word[RLEN_W-1:0] = len;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DIGIT_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_DIGIT_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_RADIX_LEN;
      csr_wdata <= word;
      @(posedge clock);
      // index past the register list must leave everything alone
      if (spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      alpha_chars = {hi, lo};
      radix_len = len;
      alphabets_loaded++;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic pick_random_alphabet();
      logic [ALPHA_SLOTS-1:0][CHAR_W-1:0] slots;
      logic [RLEN_W-1:0] len;
      logic [CHAR_W-1:0] c;
      int mode, i, j;
      bit clash;
      for (i = 0; i < ALPHA_SLOTS; i++) begin
         do begin
            c = CHAR_W'($urandom_range(1, 255));
            clash = is_blocked(c);
            for (j = 0; j < i; j++)
               if (slots[j] == c) clash = 1'b1;
         end while (clash);
         slots[i] = c;
      end
      case ($urandom_range(3))
         0:       len = 5'd2;
         1:       len = RLEN_W'(MAX_RADIX);
         default: len = RLEN_W'($urandom_range(2, MAX_RADIX));
      endcase
      mode = $urandom_range(9);
      if (mode == 7) begin
         len = $urandom_range(1) ? RLEN_W'($urandom_range(1))
                                 : RLEN_W'($urandom_range(MAX_RADIX + 1, 31));
      end else if (mode == 8) begin
         i = $urandom_range(len - 2);
         j = $urandom_range(i + 1, len - 1);
         slots[j] = slots[i];
      end else if (mode == 9) begin
         case ($urandom_range(3))
            0:       c = CHAR_NUL;
            default: c = prefix_char();
         endcase
         slots[$urandom_range(len - 1)] = c;
      end
      load_alphabet(slots[7:0], slots[15:8], len, $urandom_range(4) == 0);
   endtask

   // Mostly well-formed texts over the current alphabet, some noise and broken ones.
   task automatic build_random_text();
      int kind, n, used;
      text_buf.delete();
      used = used_len();
      kind = $urandom_range(99);
      if (kind < 15) begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(CHAR_W'($urandom));
      end else begin
         repeat ($urandom_range(0, 4)) text_buf.push_back(prefix_char());
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 10);
         if (used > 0)
            repeat (n) text_buf.push_back(alpha_chars[$urandom_range(used - 1)]);
         if (kind >= 85) begin
            text_buf.push_back(prefix_char());
            if (used > 0)
               repeat ($urandom_range(1, 3))
                  text_buf.push_back(alpha_chars[$urandom_range(used - 1)]);
         end else if ($urandom_range(1)) begin
            text_buf.push_back(($urandom_range(3) == 0) ? CHAR_NUL : CHAR_W'($urandom));
            repeat ($urandom_range(0, 2)) text_buf.push_back(CHAR_W'($urandom));
         end
      end
      if (text_buf.size() == 0) text_buf.push_back(CHAR_W'($urandom));
   endtask

   task automatic test_reset_alphabet();
      // empty alphabet after reset: always invalid
      text_buf = '{8'hFF};
      send_text();
   endtask

   task automatic test_extremes();
      wait_idle();
      load_alphabet(64'h3736353433323130, 64'hFF65646362613938, 5'd16, 1'b0);
      text_buf = '{"7", 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_text();
      text_buf = '{CHAR_PLUS, CHAR_MINUS, "8", "0", "0", "0", "0", "0", "0", "0"};
      send_text();
   endtask

   task automatic test_terminators();
      wait_idle();
      load_alphabet(64'h3736353433323130, 64'h0000000000003938, 5'd10, 1'b0);
      // sign after digits ends the number
      text_buf = '{CHAR_CR, "5", CHAR_MINUS, "3"};
      send_text();
      // NUL ends the number
      text_buf = '{CHAR_SPACE, CHAR_MINUS, CHAR_TAB, "1", CHAR_NUL, "2"};
      send_text();
   endtask

   task automatic test_config_mid_text();
      send_char(CHAR_MINUS, 1'b0);
      send_char("1", 1'b0);
      wait_idle();
      // switch to octal halfway through the text
      load_alphabet(64'h3736353433323130, 64'h2D2B2D2B2D2B2D2B, 5'd8, 1'b1);
      send_char("7", 1'b1);
      wait_idle();
      // duplicated digit makes the alphabet invalid
      load_alphabet(64'h0000000030323130, 64'h0, 5'd4, 1'b0);
      send_char("1", 1'b1);
   endtask

   task automatic test_random(input int count);
      int target;
      target = chars_sent + count;
      wait_idle();
      pick_random_alphabet();
      while (chars_sent < target) begin
         if ($urandom_range(7) == 0) begin
            wait_idle();
            pick_random_alphabet();
         end
         build_random_text();
         send_text();
      end
   endtask

   initial begin
      push_idle_pct = 25;
      pop_idle_pct = 65;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_alphabet();
      test_extremes();
      test_terminators();
      test_config_mid_text();
      test_random(270);
      push_idle_pct = 65;
      pop_idle_pct = 25;
      test_random(270);
      push_idle_pct = 0;
      pop_idle_pct = 0;
      test_random(270);
      wait_idle();
      $display("Ran %0d characters in %0d texts over %0d alphabet settings,",
               chars_sent, texts_sent, alphabets_loaded);
      $display("checked %0d results with sender and receiver stalls in both ratios.",
               results_checked);
      if (mismatches == 0) begin
         $display("string_to_int_custom_radix: match");
      end else begin
         $display("string_to_int_custom_radix: mismatch");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Timeout with %0d results still pending", pending_numbers.size());
      $display("string_to_int_custom_radix: mismatch");
      $finish;
   end

endmodule

// File: string_to_int_custom_radix.f
+incdir+hdl
hdl/stoi_pkg.sv
hdl/stoi_csr.sv
hdl/stoi_front.sv
hdl/stoi_fifo.sv
hdl/stoi_back.sv
hdl/string_to_int_custom_radix.sv
test/testbench.sv
